FILE: rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Tag codes, payload sizes and word classification for the word-pair
// compressor.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int WORD_W    = 64;
  localparam int TAG_W     = 3;
  localparam int LEN_W     = 4;                  // payload length, 0 to 8 bytes
  localparam int PKT_BYTES = 17;                 // tag byte plus two raw payloads
  localparam int PKT_W     = 8 * PKT_BYTES;
  localparam int CNT_W     = $clog2(PKT_BYTES + 1);

  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam tag_t TAG_ZERO   = 3'd0;
  localparam tag_t TAG_NIBBLE = 3'd1;
  localparam tag_t TAG_SBYTE  = 3'd2;
  localparam tag_t TAG_SHALF  = 3'd3;
  localparam tag_t TAG_REPH   = 3'd4;
  localparam tag_t TAG_REPB   = 3'd5;
  localparam tag_t TAG_SWORD  = 3'd6;
  localparam tag_t TAG_RAW    = 3'd7;

  // first matching pattern wins
  function automatic tag_t fpc_classify(input word_t w);
    logic rep_b;
    logic rep_h;
    rep_b = 1'b1;
    for (int i = 1; i < 8; i++) begin
      if (w[8*i +: 8] != w[7:0]) rep_b = 1'b0;
    end
    rep_h = 1'b1;
    for (int i = 1; i < 4; i++) begin
      if (w[16*i +: 16] != w[15:0]) rep_h = 1'b0;
    end
    if (w == '0)                                   return TAG_ZERO;
    else if (rep_b)                                return TAG_REPB;
    else if (rep_h)                                return TAG_REPH;
    else if (&w[63:3]  || ~|w[63:3])              return TAG_NIBBLE;
    else if (&w[63:7]  || ~|w[63:7])              return TAG_SBYTE;
    else if (&w[63:15] || ~|w[63:15])             return TAG_SHALF;
    else if (&w[63:31] || ~|w[63:31])             return TAG_SWORD;
    else                                           return TAG_RAW;
  endfunction

  function automatic len_t fpc_len(input tag_t t);
    case (t)
      TAG_ZERO:                        return 4'd0;
      TAG_NIBBLE, TAG_SBYTE, TAG_REPB: return 4'd1;
      TAG_SHALF, TAG_REPH:             return 4'd2;
      TAG_SWORD:                       return 4'd4;
      default:                         return 4'd8;
    endcase
  endfunction

  // low bytes of the word, zero above; nibble tag keeps only bits 3:0
  function automatic word_t fpc_payload(input word_t w, input tag_t t);
    case (t)
      TAG_ZERO:                 return '0;
      TAG_NIBBLE:               return {60'd0, w[3:0]};
      TAG_SBYTE, TAG_REPB:      return {56'd0, w[7:0]};
      TAG_SHALF, TAG_REPH:      return {48'd0, w[15:0]};
      TAG_SWORD:                return {32'd0, w[31:0]};
      default:                  return w;
    endcase
  endfunction

endpackage

FILE: rtl/fpc_word_pair_compressor.sv
// ----------------------------------------------------------------------------
// fpc_word_pair_compressor
// Frequent-pattern compressor: 64-bit words in, pairs of words packed into a
// byte stream of one tag byte and little-endian payloads.
// ----------------------------------------------------------------------------
// usage:
//   slave side: one 64-bit word per transfer, s_tlast on the final word of
//   a stream. master side: one compressed byte per transfer; m_tlast marks
//   the last byte of each packet, m_tuser the last byte of a stream.
//   the first word of a pair is held and gives no output; the second (or a
//   lone final word) makes a packet of 1 to 17 bytes.
// path: a pair sits in the input register once its second or lone final
//   word is taken; its packet is loaded into the output shift register once
//   that is free, and its bytes are shown one per cycle while m_tready is high.
// throughput: set by the byte-wide output shift register, one byte per
//   cycle while m_tready is high; a pair gives a packet of 1 to 17 bytes.
//   a new word is taken while the previous packet is still draining.
// reset: clears the held-word flag, input and output valids; no stream in flight.
// stall: with m_tready low the shift register holds, the input register
//   fills and s_tready falls until the packet drains.
// ----------------------------------------------------------------------------
module fpc_word_pair_compressor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // word_in
  input  logic                  s_tlast,   // word_last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // out_byte
  output logic                  m_tlast,   // run_last
  output logic                  m_tuser    // stream_end
);
  import fpc_pkg::*;

  // first word of a pair, waiting for its partner
  logic                 held_valid;
  word_t                held_word;

  // input register: a pair (second word zero for a lone final word)
  logic                 s1_valid;
  word_t                s1_a;
  word_t                s1_b;
  logic                 s1_last;

  // output shift register, byte 0 is on the bus
  logic                 pk_valid;
  logic [PKT_W-1:0]     pk_data;
  logic [CNT_W-1:0]     pk_cnt;
  logic                 pk_last;

  logic                 in_fire;
  logic                 in_pair;
  logic                 pk_done;
  logic                 pk_free;
  logic                 pk_load;

  tag_t                 tag_a;
  tag_t                 tag_b;
  len_t                 len_a;
  len_t                 len_b;
  word_t                pay_a;
  word_t                pay_b;
  logic [PKT_W-1:0]     pk_data_next;
  logic [CNT_W-1:0]     pk_cnt_next;

  assign pk_done  = pk_valid && m_tready && (pk_cnt == CNT_W'(1));
  assign pk_free  = !pk_valid || pk_done;
  assign pk_load  = s1_valid && pk_free;
  assign s_tready = !s1_valid || pk_free;
  assign in_fire  = s_tvalid && s_tready;
  // a word makes output if it completes a pair or ends the stream
  assign in_pair  = in_fire && (held_valid || s_tlast);

  // classification and packing
  always_comb begin
    tag_a = fpc_classify(s1_a);
    tag_b = fpc_classify(s1_b);
    len_a = fpc_len(tag_a);
    len_b = fpc_len(tag_b);
    pay_a = fpc_payload(s1_a, tag_a);
    pay_b = fpc_payload(s1_b, tag_b);
    pk_data_next = '0;
    pk_data_next[7:0]  = {2'b00, tag_b, tag_a};
    pk_data_next[71:8] = pay_a;
    // second payload follows right after the first
    case (len_a)
      4'd0:    pk_data_next[71:8]   = pk_data_next[71:8]   | pay_b;
      4'd1:    pk_data_next[79:16]  = pk_data_next[79:16]  | pay_b;
      4'd2:    pk_data_next[87:24]  = pk_data_next[87:24]  | pay_b;
      4'd4:    pk_data_next[103:40] = pk_data_next[103:40] | pay_b;
      default: pk_data_next[135:72] = pay_b;
    endcase
    pk_cnt_next = CNT_W'(1) + CNT_W'(len_a) + CNT_W'(len_b);
  end

  // pair holding
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_fire) begin
      if (held_valid) begin
        held_valid <= 1'b0;
      end else if (!s_tlast) begin
        held_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !held_valid && !s_tlast) begin
      held_word <= s_tdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_pair) begin
      s1_valid <= 1'b1;
    end else if (pk_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pair) begin
      s1_a    <= held_valid ? held_word : s_tdata;
      s1_b    <= held_valid ? s_tdata : '0;
      s1_last <= s_tlast;
    end
  end

  // output shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      pk_valid <= 1'b0;
      pk_cnt   <= '0;
    end else if (pk_load) begin
      pk_valid <= 1'b1;
      pk_cnt   <= pk_cnt_next;
    end else if (pk_done) begin
      pk_valid <= 1'b0;
      pk_cnt   <= '0;
    end else if (pk_valid && m_tready) begin
      pk_cnt   <= pk_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pk_load) begin
      pk_data <= pk_data_next;
      pk_last <= s1_last;
    end else if (pk_valid && m_tready) begin
      pk_data <= {8'd0, pk_data[PKT_W-1:8]};
    end
  end

  assign m_tvalid = pk_valid;
  assign m_tdata  = pk_data[7:0];
  assign m_tlast  = pk_cnt == CNT_W'(1);
  assign m_tuser  = pk_last && (pk_cnt == CNT_W'(1));

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    pk_valid |-> (pk_cnt != '0) && (pk_cnt <= CNT_W'(PKT_BYTES)))
    else $error("packet byte count out of range");

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tuser |-> m_tlast)
    else $error("stream end not on a run's last byte");

  a_held_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tlast) |=> !held_valid)
    else $error("word still held after end of stream");

  a_s1_waits: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !pk_free) |=> s1_valid && $stable(s1_a) && $stable(s1_b))
    else $error("input register lost a pair while output busy");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !pk_valid |-> pk_cnt == '0)
    else $error("byte count left over with no packet");
`endif

endmodule

FILE: tb/fpc_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_stream_checker
// Watches both stream channels of the word-pair compressor, predicts the
// compressed bytes of every accepted word and compares each byte leaving the
// block with the oldest prediction.
// ----------------------------------------------------------------------------
module fpc_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  output int          fail_total,
  output int          bytes_pending
);
  import fpc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       word_end;
    logic       stream_end;
  } comp_byte_t;

  comp_byte_t expected_bytes[$];
  logic       pair_open;
  word_t      pair_first;
  int         fail_count;

  initial begin
    fail_total    = 0;
    bytes_pending = 0;
    fail_count    = 0;
    pair_open     = 1'b0;
    pair_first    = '0;
  end

  // first matching pattern wins
  function automatic tag_t pattern_tag(input word_t w);
    if (w == '0)                                  return TAG_ZERO;
    if (w == {8{w[7:0]}})                         return TAG_REPB;
    if (w == {4{w[15:0]}})                        return TAG_REPH;
    if (w + 64'h8 < 64'h10)                       return TAG_NIBBLE;
    if (w + 64'h80 < 64'h100)                     return TAG_SBYTE;
    if (w + 64'h8000 < 64'h1_0000)                return TAG_SHALF;
    if (w + 64'h8000_0000 < 64'h1_0000_0000)      return TAG_SWORD;
    return TAG_RAW;
  endfunction

  function automatic int payload_bytes(input tag_t t);
    case (t)
      TAG_ZERO:                        return 0;
      TAG_NIBBLE, TAG_SBYTE, TAG_REPB: return 1;
      TAG_SHALF, TAG_REPH:             return 2;
      TAG_SWORD:                       return 4;
      default:                         return 8;
    endcase
  endfunction

  // append one predicted byte at the tail of the queue
  task automatic queue_byte(input comp_byte_t b);
    expected_bytes = {expected_bytes, b};
  endtask

  // first word of a pair is held; a second or lone final word gives a packet
  task automatic predict_word(input word_t w, input logic last);
    word_t      pair_words [2];
    tag_t       pair_tags [2];
    logic [7:0] packet [17];
    word_t      body;
    int         n_words;
    int         n;
    int         len;
    if (!pair_open && !last) begin
      pair_open  = 1'b1;
      pair_first = w;
    end else begin
      if (pair_open) begin
        pair_words[0] = pair_first;
        pair_words[1] = w;
        n_words       = 2;
      end else begin
        pair_words[0] = w;
        n_words       = 1;
      end
      pair_tags[1] = TAG_ZERO;
      for (int k = 0; k < n_words; k++) pair_tags[k] = pattern_tag(pair_words[k]);
      packet[0] = {2'b00, pair_tags[1], pair_tags[0]};
      n = 1;
      for (int k = 0; k < n_words; k++) begin
        len  = payload_bytes(pair_tags[k]);
        body = (pair_tags[k] == TAG_NIBBLE) ? {60'd0, pair_words[k][3:0]} : pair_words[k];
        for (int i = 0; i < len; i++) begin
          packet[n] = body[8*i +: 8];
          n++;
        end
      end
      for (int i = 0; i < n; i++)
        queue_byte(comp_byte_t'({packet[i], i == n - 1, (i == n - 1) && last}));
      pair_open  = 1'b0;
      pair_first = '0;
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    comp_byte_t want;
    if (rst) begin
      expected_bytes.delete();
      pair_open  = 1'b0;
      pair_first = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          note_failure($sformatf("unexpected byte %02h last %b end %b",
                                 m_tdata, m_tlast, m_tuser));
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.data || m_tlast !== want.word_end ||
              m_tuser !== want.stream_end)
            note_failure($sformatf("exp byte %02h last %b end %b, got %02h %b %b",
                                   want.data, want.word_end, want.stream_end,
                                   m_tdata, m_tlast, m_tuser));
        end
      end
      if (s_tvalid && s_tready) predict_word(s_tdata, s_tlast);
    end
    fail_total    <= fail_count;
    bytes_pending <= expected_bytes.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the word-pair compressor: a directed set of words covering
// every tag and its boundaries, then random streams with random idle gaps on
// the word side and random back-pressure on the byte side. A checker beside
// the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_top;
  import fpc_pkg::*;

  localparam int RANDOM_WORDS = 188;
  localparam int CALM_WORDS   = 40;      // tail of the run without idling
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;      // more than one full packet

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;            // word_in
  logic        s_tlast  = 1'b0;          // word_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;                  // out_byte
  logic        m_tlast;                  // run_last
  logic        m_tuser;                  // stream_end

  int          fail_total;
  int          bytes_pending;
  int          cycle_count = 0;
  logic        calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fpc_word_pair_compressor i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  fpc_stream_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .fail_total    (fail_total),
    .bytes_pending (bytes_pending)
  );

  // watchdog: a hung handshake or a lost byte ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fpc_word_pair_compressor verification failed");
      $finish;
    end
  end

  // byte side back-pressure: random ready stretches and stall bursts,
  // always ready once the calm tail starts
  initial begin
    @(posedge clk);
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // one word transfer; valid stays high into the next call when no gap
  task automatic push_word(input word_t w, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // random word biased toward each compressible pattern and its edges
  function automatic word_t pick_word();
    word_t raw;
    word_t edge_val;
    int    bits;
    raw  = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       bits = 4;
      1:       bits = 8;
      2:       bits = 16;
      default: bits = 32;
    endcase
    edge_val = word_t'(1) << (bits - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {8{raw[7:0]}};
      2:       return {4{raw[15:0]}};
      3, 4, 5: return word_t'($signed(raw << (64 - bits)) >>> (64 - bits));
      6: begin
        // just inside or just outside a signed range
        case ($urandom_range(0, 3))
          0:       return edge_val - 1;
          1:       return '0 - edge_val;
          2:       return edge_val;
          default: return '0 - edge_val - 1;
        endcase
      end
      default: return raw;
    endcase
  endfunction

  // directed words: every tag, words just inside and just outside each signed
  // range, lone final words, a one-word stream and an even stream ending on a pair
  word_t directed_words [23] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0101_0101_0101_0101, 64'h1234_1234_1234_1234,
    64'h00FF_00FF_00FF_00FF,
    64'h0000_0000_0000_0007,
    64'hFFFF_FFFF_FFFF_FFF8, 64'h0000_0000_0000_0008,
    64'hFFFF_FFFF_FFFF_FFF7, 64'h0000_0000_0000_007F,
    64'hFFFF_FFFF_FFFF_FF80, 64'h0000_0000_0000_0080,
    64'hFFFF_FFFF_FFFF_7FFF, 64'hFFFF_FFFF_FFFF_8000,
    64'h0000_0000_0000_8000, 64'h0000_0000_7FFF_FFFF,
    64'hFFFF_FFFF_8000_0000, 64'h0000_0000_8000_0000,
    64'hFFFF_FFFF_7FFF_FFFF, 64'h8000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
    64'hA5C3_0F96_5A3C_F069
  };

  initial begin
    logic last;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_words[i]) begin
      last = (i == 4) || (i == 5) || (i == 13) || (i == 22);
      push_word(directed_words[i], last);
    end

    // random streams of varying length; the final word closes the stream
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) calm <= 1'b1;
      last = (n == RANDOM_WORDS - 1) || ($urandom_range(0, 9) == 0);
      push_word(pick_word(), last);
    end
    calm     <= 1'b1;
    s_tvalid <= 1'b0;

    // let the last prediction land, drain, then watch for stray bytes
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_total == 0 && bytes_pending == 0) begin
      $display("fpc_word_pair_compressor verification clean");
    end else begin
      $display("fpc_word_pair_compressor verification failed");
    end
    $finish;
  end

endmodule
